[hw/rtl/udpcc_pkg.sv]
// Package for the UDP checksum checker: payload structs, status codes and
// the byte counter width with the constants derived from it.
// Depends on nothing; imported by udp_checksum_checker_unit.
package udpcc_pkg;

  // Width of the datagram byte counter (16 to 32).
  localparam int LENGTH_BITS = 16;
  // Number of 16-bit chunks of the byte counter that enter the sum.
  localparam int CNT_CHUNKS  = (LENGTH_BITS + 15) / 16;
  // Terms of the final sum: accumulator, data word, protocol, count chunks.
  localparam int SUM_TERMS   = CNT_CHUNKS + 3;
  localparam int FSUM_W      = 16 + $clog2(SUM_TERMS);

  localparam logic [15:0] UDP_PROTOCOL = 16'd17;
  localparam int          BYTE_SHIFT   = 8;
  localparam logic [2:0]  HDR_WORDS    = 3'd4;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_CORRECT   = 2'd1,
    ST_INCORRECT = 2'd2,
    ST_UNCHECKED = 2'd3
  } status_t;

  typedef struct packed {
    logic        func;
    logic [15:0] data_word;
    logic        odd_byte;
    logic        last;
    logic        fragmented;
    logic        truncated;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] length_field;
    logic [15:0] checksum_field;
    logic [15:0] residual;
  } out_item_t;

endpackage

[hw/rtl/udp_checksum_checker_unit.sv]
// Top level of the UDP checksum checker: input register, ones-complement
// sum, header capture, byte counter and result register.
// Depends on udpcc_pkg.
//
// Usage: the input channel carries one 16-bit word per request, first the
// pseudo-header address words (func low), then the datagram words (func
// high). The datagram word flagged last closes the datagram and produces
// exactly one request on the output channel with the status, the four
// captured header words and the residual of the checksum.
// Timing: an accepted word is held in the input register and is then added
// into the sum state; for a last word the result register is loaded at that
// same edge, and out_valid rises with the loaded result.
// Throughput: one word per cycle while in_stall is low; the sum accumulator
// uses a single 16-bit ones-complement add.
// Stall: the output register holds a result while out_stall is high. Words
// that give no result keep flowing; a last word waits in the input register
// until the output register is free, and in_stall is raised meanwhile.
// Reset: synchronous on rst_n low; both channels empty, the sum, the byte
// count, the word index and the captured header words return to zero.
// After each result the same state returns to zero for the next datagram.
module udp_checksum_checker_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  udpcc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output udpcc_pkg::out_item_t out_data
);
  import udpcc_pkg::*;

  // Input register.
  logic       s_valid_r, s_valid_nxt;
  in_item_t   s_item_r;

  // Checker state.
  logic [15:0]            sum_acc_r, sum_acc_nxt;
  logic [LENGTH_BITS-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [2:0]             word_idx_r, word_idx_nxt;
  logic [15:0]            port_src_r, port_src_nxt;
  logic [15:0]            port_dst_r, port_dst_nxt;
  logic [15:0]            len_r, len_nxt;
  logic [15:0]            sum_field_r, sum_field_nxt;

  // Result register.
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  logic                      in_acc;
  logic                      s_res;
  logic                      s_go;
  logic                      res_load;
  logic [15:0]               word_m;
  logic [16:0]               acc_add;
  logic [LENGTH_BITS:0]      cnt_sum;
  logic [LENGTH_BITS-1:0]    cnt_new;
  logic [CNT_CHUNKS*16-1:0]  cnt_pad;
  logic [FSUM_W-1:0]         fsum;
  logic [16:0]               fold1;
  logic [15:0]               fold2;
  logic [15:0]               residual;
  status_t                   status;

  assign s_res    = s_item_r.func && s_item_r.last;
  // A last word may only move on when the result register can take it.
  assign s_go     = !s_res || !out_valid_r || !out_stall;
  assign in_stall = s_valid_r && !s_go;
  assign in_acc   = in_valid && !in_stall;
  assign res_load = s_valid_r && s_res;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (in_acc) begin
      s_valid_nxt = 1'b1;
    end else if (s_go) begin
      s_valid_nxt = 1'b0;
    end
  end

  // Datagram word with the padding byte forced to zero.
  assign word_m = (s_item_r.func && s_item_r.odd_byte) ?
                  (s_item_r.data_word & (16'hFF << BYTE_SHIFT)) : s_item_r.data_word;

  assign acc_add = {1'b0, sum_acc_r} + {1'b0, word_m};

  // Saturating byte count.
  assign cnt_sum = {1'b0, byte_cnt_r} +
                   (LENGTH_BITS + 1)'(s_item_r.odd_byte ? 2'd1 : 2'd2);
  assign cnt_new = cnt_sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : cnt_sum[LENGTH_BITS-1:0];
  assign cnt_pad = (CNT_CHUNKS * 16)'(cnt_new);

  // Final sum done as one wide add and two folds; the ones-complement
  // result matches the word-by-word end-around-carry chain.
  always_comb begin
    fsum = FSUM_W'(sum_acc_r) + FSUM_W'(word_m) + FSUM_W'(UDP_PROTOCOL);
    for (int k = 0; k < CNT_CHUNKS; k++) begin
      fsum = fsum + FSUM_W'(cnt_pad[k*16 +: 16]);
    end
  end

  assign fold1    = 17'(fsum[15:0]) + 17'(fsum[FSUM_W-1:16]);
  assign fold2    = fold1[15:0] + 16'(fold1[16]);
  assign residual = ~fold2;

  // If the last word is itself the fourth header word, the checksum field is taken from it directly.
  always_comb begin
    logic [15:0] chk;
    chk = (word_idx_r == 3'd3) ? word_m : sum_field_r;
    if (chk == 16'd0) begin
      status = ST_NONE;
    end else if (s_item_r.fragmented || s_item_r.truncated) begin
      status = ST_UNCHECKED;
    end else if (residual == 16'd0) begin
      status = ST_CORRECT;
    end else begin
      status = ST_INCORRECT;
    end
  end

  always_comb begin
    sum_acc_nxt   = sum_acc_r;
    byte_cnt_nxt  = byte_cnt_r;
    word_idx_nxt  = word_idx_r;
    port_src_nxt  = port_src_r;
    port_dst_nxt  = port_dst_r;
    len_nxt       = len_r;
    sum_field_nxt = sum_field_r;
    if (s_valid_r && s_go) begin
      sum_acc_nxt = acc_add[15:0] + 16'(acc_add[16]);
      if (s_item_r.func) begin
        byte_cnt_nxt = cnt_new;
        case (word_idx_r)
          3'd0:    port_src_nxt  = word_m;
          3'd1:    port_dst_nxt  = word_m;
          3'd2:    len_nxt       = word_m;
          3'd3:    sum_field_nxt = word_m;
          default: ;
        endcase
        if (word_idx_r < HDR_WORDS) begin
          word_idx_nxt = word_idx_r + 3'd1;
        end
      end
      if (s_res) begin
        sum_acc_nxt   = '0;
        byte_cnt_nxt  = '0;
        word_idx_nxt  = '0;
        port_src_nxt  = '0;
        port_dst_nxt  = '0;
        len_nxt       = '0;
        sum_field_nxt = '0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_load && s_go) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.status         = status;
      out_data_nxt.source_port    = (word_idx_r == 3'd0) ? word_m : port_src_r;
      out_data_nxt.dest_port      = (word_idx_r == 3'd1) ? word_m : port_dst_r;
      out_data_nxt.length_field   = (word_idx_r == 3'd2) ? word_m : len_r;
      out_data_nxt.checksum_field = (word_idx_r == 3'd3) ? word_m : sum_field_r;
      out_data_nxt.residual       = residual;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      sum_acc_r   <= '0;
      byte_cnt_r  <= '0;
      word_idx_r  <= '0;
      port_src_r  <= '0;
      port_dst_r  <= '0;
      len_r       <= '0;
      sum_field_r <= '0;
    end else begin
      s_valid_r   <= s_valid_nxt;
      out_valid_r <= out_valid_nxt;
      sum_acc_r   <= sum_acc_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      word_idx_r  <= word_idx_nxt;
      port_src_r  <= port_src_nxt;
      port_dst_r  <= port_dst_nxt;
      len_r       <= len_nxt;
      sum_field_r <= sum_field_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_item_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // The header word index saturates after the four header words.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    word_idx_r <= HDR_WORDS)
    else $error("word index beyond header");

  // Issuing a result clears the datagram state.
  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && s_go) |=> (word_idx_r == 3'd0 && byte_cnt_r == '0 && sum_acc_r == 16'd0))
    else $error("state not cleared after result");

  // A correct status always comes with a zero residual.
  a_correct_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_CORRECT) |-> out_data_r.residual == 16'd0)
    else $error("correct status with nonzero residual");

  // Status none appears exactly when the checksum field is zero.
  a_none_iff_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.status == ST_NONE) == (out_data_r.checksum_field == 16'd0)))
    else $error("status none does not match checksum field");

  // A waiting last word never overwrites a result that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && res_load) |-> in_stall || !s_go)
    else $error("result register overwritten while stalled");
`endif

endmodule
